@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the request parser.
// Expects a clock clk_i and an active-low reset rst_ni in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, switched off while reset is asserted.
`define RRP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same check, with the implication built from the caller's pre and post.
`define RRP_ASSERT_IMPL(label, pre, post, msg) \
  `RRP_ASSERT(label, (pre) |-> (post), msg)

`endif

@@ sv/rrp_pkg.sv @@
// Package of the request parser: widths, codes, characters and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rrp_pkg;

  localparam int unsigned INT_LINE_MAX = 31;
  localparam int unsigned LEN_BITS     = 26;
  localparam int unsigned ARGS_BITS    = 14;
  localparam int unsigned NUM_W        = LEN_BITS + 1;
  localparam int unsigned LC_W         = $clog2(INT_LINE_MAX + 1);

  localparam logic [NUM_W-1:0]     NUM_SAT          = {NUM_W{1'b1}};
  localparam logic [ARGS_BITS-1:0] MAX_ARGS_RESET   = ARGS_BITS'(10000);
  localparam logic [LEN_BITS-1:0]  MAX_ARG_LEN_RESET = LEN_BITS'(33554432);

  // Configuration register indexes
  localparam logic CFG_MAX_ARGS    = 1'b0;
  localparam logic CFG_MAX_ARG_LEN = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NO_STAR   = 3'd0;
  localparam logic [2:0] ERR_BAD_COUNT = 3'd1;
  localparam logic [2:0] ERR_NO_DOLLAR = 3'd2;
  localparam logic [2:0] ERR_BAD_LEN   = 3'd3;
  localparam logic [2:0] ERR_NO_CRLF   = 3'd4;
  localparam logic [2:0] ERR_BAD_INT   = 3'd5;

  // Characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [6:0] {
    PH_STAR   = 7'b0000001,
    PH_COUNT  = 7'b0000010,
    PH_DOLLAR = 7'b0000100,
    PH_LEN    = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_CR     = 7'b0100000,
    PH_LF     = 7'b1000000
  } phase_e;

  typedef enum logic [1:0] {
    LINE_MORE = 2'd0,
    LINE_DONE = 2'd1,
    LINE_BAD  = 2'd2
  } line_status_e;

  // State of one integer line being parsed
  typedef struct packed {
    logic             pending_cr;
    logic [LC_W-1:0]  line_count;
    logic             number_sign;
    logic             sign_seen;
    logic             digit_seen;
    logic [NUM_W-1:0] number_value;
  } line_t;

endpackage

`default_nettype wire

@@ sv/rrp_if.sv @@
// Handshake channels of the request parser: input bytes and result items.
// Depends on rrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface rrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface rrp_out_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [7:0]                     data_byte;
  logic [rrp_pkg::ARGS_BITS-1:0]  arg_index;
  logic [rrp_pkg::LEN_BITS-1:0]   arg_length;
  logic                           last_arg;
  logic [2:0]                     error_code;

  modport source (
    output valid, output kind, output data_byte, output arg_index,
    output arg_length, output last_arg, output error_code, input ready
  );
  modport sink (
    input valid, input kind, input data_byte, input arg_index,
    input arg_length, input last_arg, input error_code, output ready
  );
endinterface

`default_nettype wire

@@ sv/rrp_int_line.sv @@
// Integer line parser: takes one byte of a count or length line and gives the
// updated line state and whether the line goes on, is complete or is malformed.
// Depends on rrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrp_int_line (
  input  wire logic [7:0]            byte_i,
  input  wire rrp_pkg::line_t        line_i,
  output rrp_pkg::line_t             line_o,
  output rrp_pkg::line_status_e      status_o
);

  typedef struct packed {
    rrp_pkg::line_t st;
    logic           ok;
  } char_res_t;

  localparam int unsigned ACC_W = rrp_pkg::NUM_W + 4;

  // One character of the line; saturating multiply-by-ten accumulate on digits
  function automatic char_res_t line_char(input rrp_pkg::line_t s, input logic [7:0] c);
    char_res_t       r;
    logic            digit;
    logic            space;
    logic [ACC_W-1:0] acc;
    r.st  = s;
    r.ok  = 1'b1;
    digit = (c >= rrp_pkg::CH_ZERO) && (c <= rrp_pkg::CH_NINE);
    space = (c == rrp_pkg::CH_SPACE) || ((c >= rrp_pkg::CH_TAB) && (c <= rrp_pkg::CH_CR));
    acc   = (ACC_W'(s.number_value) << 3) + (ACC_W'(s.number_value) << 1)
          + ACC_W'(c - rrp_pkg::CH_ZERO);
    if (s.line_count >= rrp_pkg::LC_W'(rrp_pkg::INT_LINE_MAX)) begin
      r.ok = 1'b0;
    end else begin
      r.st.line_count = s.line_count + rrp_pkg::LC_W'(1);
      if (!digit) begin
        if (s.sign_seen || s.digit_seen) begin
          r.ok = 1'b0;
        end else if (space) begin
          r.ok = 1'b1;
        end else if ((c == rrp_pkg::CH_PLUS) || (c == rrp_pkg::CH_MINUS)) begin
          r.st.sign_seen   = 1'b1;
          r.st.number_sign = (c == rrp_pkg::CH_MINUS);
        end else begin
          r.ok = 1'b0;
        end
      end else begin
        r.st.digit_seen   = 1'b1;
        r.st.number_value = (acc > ACC_W'(rrp_pkg::NUM_SAT)) ? rrp_pkg::NUM_SAT
                                                             : acc[rrp_pkg::NUM_W-1:0];
      end
    end
    return r;
  endfunction

  char_res_t      cr_res;
  char_res_t      byte_res;
  rrp_pkg::line_t mid;
  logic           mid_bad;
  logic           mid_done;

  // Resolve a held CR first: LF ends the line, anything else makes it a line character
  always_comb begin
    mid      = line_i;
    mid_bad  = 1'b0;
    mid_done = 1'b0;
    cr_res   = line_char(line_i, rrp_pkg::CH_CR);
    if (line_i.pending_cr) begin
      mid.pending_cr = 1'b0;
      if (byte_i == rrp_pkg::CH_LF) begin
        mid_done = line_i.digit_seen && (line_i.line_count != '0);
        mid_bad  = !mid_done;
      end else if (!cr_res.ok) begin
        mid_bad = 1'b1;
      end else begin
        mid            = cr_res.st;
        mid.pending_cr = 1'b0;
      end
    end
  end

  always_comb begin
    byte_res = line_char(mid, byte_i);
    line_o   = mid;
    status_o = rrp_pkg::LINE_MORE;
    priority if (mid_bad) begin
      status_o = rrp_pkg::LINE_BAD;
    end else if (mid_done) begin
      status_o = rrp_pkg::LINE_DONE;
    end else if (byte_i == rrp_pkg::CH_CR) begin
      line_o.pending_cr = 1'b1;
    end else if (byte_res.ok) begin
      line_o = byte_res.st;
    end else begin
      status_o = rrp_pkg::LINE_BAD;
    end
  end

endmodule

`default_nettype wire

@@ sv/resp_request_parser_top.sv @@
// Top level of the request parser: phase sequencer, configuration registers and
// result register. Depends on rrp_pkg, rrp_if, rrp_int_line and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Parses '*' count CRLF followed by count bulk strings '$' length CRLF data CRLF,
// one byte per item. A data byte or end-of-argument result appears in the result
// register on the cycle after its byte is taken; input is taken whenever that
// register is empty or being emptied, so the sustained rate is one byte per clock
// while out_o.ready stays high. Count and length lines follow strtol rules
// (whitespace, sign, digits, at most 31 characters before CRLF) with saturating
// accumulation. Any protocol fault yields one error result and the block then
// swallows every byte without result until reset. Writes to max_args (index 0) and
// max_arg_len (index 1) take effect at once; the user must make them only while no
// request is in progress, unchecked by the block. No clearing pass follows reset.
module resp_request_parser_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [rrp_pkg::LEN_BITS-1:0]  cfg_wdata_i,
  rrp_in_if.sink                             in_i,
  rrp_out_if.source                          out_o
);

  localparam int unsigned AB = rrp_pkg::ARGS_BITS;
  localparam int unsigned LB = rrp_pkg::LEN_BITS;

  rrp_pkg::phase_e       phase_q, phase_d;
  rrp_pkg::line_t        line_q, line_d, line_nxt;
  rrp_pkg::line_status_e line_status;
  logic [AB-1:0]         max_args_q;
  logic [LB-1:0]         max_arg_len_q;
  logic [AB-1:0]         args_left_q, args_left_d;
  logic [AB-1:0]         current_arg_q, current_arg_d;
  logic [LB-1:0]         bytes_left_q, bytes_left_d;
  logic [LB-1:0]         current_len_q, current_len_d;
  logic                  closed_q, closed_d;

  logic                  accept;
  logic                  neg;
  logic                  is_last;
  logic                  res_load;
  logic [1:0]            res_kind;
  logic [7:0]            res_data;
  logic [AB-1:0]         res_idx;
  logic [LB-1:0]         res_len;
  logic                  res_last;
  logic [2:0]            res_code;

  logic                  out_valid_q;
  logic [1:0]            out_kind_q;
  logic [7:0]            out_data_q;
  logic [AB-1:0]         out_idx_q;
  logic [LB-1:0]         out_len_q;
  logic                  out_last_q;
  logic [2:0]            out_code_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  rrp_int_line u_int_line (
    .byte_i   (in_i.in_byte),
    .line_i   (line_q),
    .line_o   (line_nxt),
    .status_o (line_status)
  );

  assign neg     = line_q.number_sign && (line_q.number_value != '0);
  assign is_last = (args_left_q <= AB'(1));

  always_comb begin
    phase_d       = phase_q;
    line_d        = line_q;
    args_left_d   = args_left_q;
    current_arg_d = current_arg_q;
    bytes_left_d  = bytes_left_q;
    current_len_d = current_len_q;
    closed_d      = closed_q;
    res_load      = 1'b0;
    res_kind      = rrp_pkg::KIND_ERROR;
    res_data      = '0;
    res_idx       = '0;
    res_len       = '0;
    res_last      = 1'b0;
    res_code      = rrp_pkg::ERR_NO_STAR;
    if (accept && !closed_q) begin
      unique case (phase_q)
        rrp_pkg::PH_STAR: begin
          if (in_i.in_byte != rrp_pkg::CH_STAR) begin
            res_load = 1'b1;
            res_code = rrp_pkg::ERR_NO_STAR;
          end else begin
            line_d  = '0;
            phase_d = rrp_pkg::PH_COUNT;
          end
        end
        rrp_pkg::PH_COUNT: begin
          line_d = line_nxt;
          unique case (line_status)
            rrp_pkg::LINE_BAD: begin
              res_load = 1'b1;
              res_code = rrp_pkg::ERR_BAD_INT;
            end
            rrp_pkg::LINE_DONE: begin
              if (neg || (line_q.number_value == '0)
                  || (line_q.number_value > rrp_pkg::NUM_W'(max_args_q))) begin
                res_load = 1'b1;
                res_code = rrp_pkg::ERR_BAD_COUNT;
              end else begin
                args_left_d   = line_q.number_value[AB-1:0];
                current_arg_d = '0;
                phase_d       = rrp_pkg::PH_DOLLAR;
              end
            end
            default: ;
          endcase
        end
        rrp_pkg::PH_DOLLAR: begin
          if (in_i.in_byte != rrp_pkg::CH_DOLLAR) begin
            res_load = 1'b1;
            res_code = rrp_pkg::ERR_NO_DOLLAR;
          end else begin
            line_d  = '0;
            phase_d = rrp_pkg::PH_LEN;
          end
        end
        rrp_pkg::PH_LEN: begin
          line_d = line_nxt;
          unique case (line_status)
            rrp_pkg::LINE_BAD: begin
              res_load = 1'b1;
              res_code = rrp_pkg::ERR_BAD_INT;
            end
            rrp_pkg::LINE_DONE: begin
              if (neg || (line_q.number_value > rrp_pkg::NUM_W'(max_arg_len_q))) begin
                res_load = 1'b1;
                res_code = rrp_pkg::ERR_BAD_LEN;
              end else begin
                current_len_d = line_q.number_value[LB-1:0];
                bytes_left_d  = line_q.number_value[LB-1:0];
                phase_d       = (line_q.number_value[LB-1:0] == '0) ? rrp_pkg::PH_CR
                                                                    : rrp_pkg::PH_DATA;
              end
            end
            default: ;
          endcase
        end
        rrp_pkg::PH_DATA: begin
          bytes_left_d = bytes_left_q - LB'(1);
          if (bytes_left_q == LB'(1)) begin
            phase_d = rrp_pkg::PH_CR;
          end
          res_load = 1'b1;
          res_kind = rrp_pkg::KIND_DATA;
          res_data = in_i.in_byte;
          res_idx  = current_arg_q;
          res_len  = current_len_q;
          res_code = rrp_pkg::ERR_NO_STAR;
        end
        rrp_pkg::PH_CR: begin
          if (in_i.in_byte != rrp_pkg::CH_CR) begin
            res_load = 1'b1;
            res_code = rrp_pkg::ERR_NO_CRLF;
          end else begin
            phase_d = rrp_pkg::PH_LF;
          end
        end
        rrp_pkg::PH_LF: begin
          res_load = 1'b1;
          if (in_i.in_byte != rrp_pkg::CH_LF) begin
            res_code = rrp_pkg::ERR_NO_CRLF;
          end else begin
            args_left_d   = is_last ? '0 : args_left_q - AB'(1);
            current_arg_d = current_arg_q + AB'(1);
            phase_d       = is_last ? rrp_pkg::PH_STAR : rrp_pkg::PH_DOLLAR;
            res_kind      = rrp_pkg::KIND_END;
            res_idx       = current_arg_q;
            res_len       = current_len_q;
            res_last      = is_last;
            res_code      = rrp_pkg::ERR_NO_STAR;
          end
        end
        default: begin
          phase_d = rrp_pkg::PH_STAR;
        end
      endcase
      // close on any error result
      if (res_load && (res_kind == rrp_pkg::KIND_ERROR)) begin
        closed_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= rrp_pkg::PH_STAR;
      line_q        <= '0;
      args_left_q   <= '0;
      current_arg_q <= '0;
      bytes_left_q  <= '0;
      current_len_q <= '0;
      closed_q      <= 1'b0;
      max_args_q    <= rrp_pkg::MAX_ARGS_RESET;
      max_arg_len_q <= rrp_pkg::MAX_ARG_LEN_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      line_q        <= line_d;
      args_left_q   <= args_left_d;
      current_arg_q <= current_arg_d;
      bytes_left_q  <= bytes_left_d;
      current_len_q <= current_len_d;
      closed_q      <= closed_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rrp_pkg::CFG_MAX_ARGS:    max_args_q    <= cfg_wdata_i[AB-1:0];
          rrp_pkg::CFG_MAX_ARG_LEN: max_arg_len_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: no reset, qualified by out_valid_q
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_kind_q <= res_kind;
      out_data_q <= res_data;
      out_idx_q  <= res_idx;
      out_len_q  <= res_len;
      out_last_q <= res_last;
      out_code_q <= res_code;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_kind_q;
  assign out_o.data_byte  = out_data_q;
  assign out_o.arg_index  = out_idx_q;
  assign out_o.arg_length = out_len_q;
  assign out_o.last_arg   = out_last_q;
  assign out_o.error_code = out_code_q;

`include "assert_macros.svh"

  `RRP_ASSERT_IMPL(a_closed_silent, closed_q, !res_load, "result produced while closed")
  `RRP_ASSERT(a_error_closes, (res_load && (res_kind == rrp_pkg::KIND_ERROR)) |=> closed_q, "error did not close the parser")
  `RRP_ASSERT_IMPL(a_data_count, phase_q == rrp_pkg::PH_DATA, bytes_left_q != '0, "data phase with no bytes left")
  `RRP_ASSERT_IMPL(a_last_on_end, out_valid_q && out_last_q, out_kind_q == rrp_pkg::KIND_END, "last flag on a result that is not end of argument")

endmodule

`default_nettype wire
